// File: rtl/i2dtxt_pkg.sv
// Package for the integer-to-decimal text core: constants, stage type, conversion step.
package i2dtxt_pkg;

    // Geometry
    localparam int DIGITS        = 10;
    localparam int SLOTS         = 14;
    localparam int BIN_W         = 32;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int DD_PER_STAGE  = 4;
    localparam int DD_STAGES     = BIN_W / DD_PER_STAGE;
    localparam int NSTAGE        = DD_STAGES + 2;

    // Characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Register indexes
    localparam logic [1:0] CFG_MIN_DIGITS = 2'd0;
    localparam logic [1:0] CFG_GROUP_SEP  = 2'd1;
    localparam logic [1:0] CFG_SIGNED     = 2'd2;

    // Character slot order: sign, digits with separators ahead of
    // the millions, thousands and units groups
    localparam logic [3:0] SLOT_MINUS = 4'd0;
    localparam logic [3:0] DIGIT_SLOT [DIGITS] = '{
        4'd1, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd9, 4'd11, 4'd12, 4'd13
    };
    localparam int         SEP_COUNT = 3;
    localparam int         SEP_POS  [SEP_COUNT] = '{1, 4, 7};
    localparam logic [3:0] SEP_SLOT [SEP_COUNT] = '{4'd2, 4'd6, 4'd10};

    // One pipeline word in flight
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        logic             neg;
    } t_stage;

    // Four shift-and-add-3 steps of the binary to BCD conversion
    function automatic t_stage dd_steps(input t_stage s);
        t_stage r;
        r = s;
        for (int i = 0; i < DD_PER_STAGE; i++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (r.bcd[4*d +: 4] >= 4'd5) begin
                    r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

endpackage

// File: rtl/integer_to_padded_decimal_text_core.sv
// Top level: 32-bit word to padded decimal ASCII text, one character per word out.
//
// Input channel (i_in_valid / o_in_ready, i_value) takes one 32-bit word per
// handshake. Output channel (o_out_valid / i_out_ready) gives one character
// word per handshake, o_last_char high on the final character of a value.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
// is always ready; write it only while no value is in flight.
// The first character of a value passes, after the input handshake, through
// ten pipeline registers (capture, negate, eight BCD stages of four shift
// steps each), then the character serializer and the output register.
// A value yields 1 to 14 characters, one per cycle while the receiver is
// ready; the serializer takes the next value in the cycle its last
// character leaves.
// Reset (synchronous, active low) empties the pipeline, drops o_out_valid
// and clears all three registers to zero. When the receiver stalls, the
// output word holds, the serializer waits, and the pipeline fills and then
// drops o_in_ready; nothing is lost or repeated.
module integer_to_padded_decimal_text_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last_char,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int NST = i2dtxt_pkg::NSTAGE;
    localparam int NSL = i2dtxt_pkg::SLOTS;
    localparam int ND  = i2dtxt_pkg::DIGITS;

    logic [3:0] r_min_digits;
    logic [7:0] r_group_separator;
    logic       r_signed_mode;

    i2dtxt_pkg::t_stage r_stage [NST];
    i2dtxt_pkg::t_stage n_stage [NST];
    logic [NST-1:0]     r_valid;
    logic [NST:0]       ld;

    logic [NSL-1:0] r_mask;
    logic [NSL-1:0] n_mask;
    logic [7:0]     r_chars [NSL];
    logic [7:0]     n_chars [NSL];
    logic [NSL-1:0] onehot;
    logic [NSL-1:0] rest;
    logic [7:0]     sel_char;
    logic           emit;
    logic           ser_can_load;
    logic           ser_load;

    logic [ND-1:0]  nz_le;
    logic [ND-1:0]  open_cnt;
    logic [3:0]     digit [ND];
    logic           any_nz;

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_last_char;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_digits      <= 4'd0;
            r_group_separator <= 8'd0;
            r_signed_mode     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                i2dtxt_pkg::CFG_MIN_DIGITS: r_min_digits      <= i_cfg_data[3:0];
                i2dtxt_pkg::CFG_GROUP_SEP:  r_group_separator <= i_cfg_data;
                i2dtxt_pkg::CFG_SIGNED:     r_signed_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline next values: capture, negate, then BCD conversion stages
    always_comb begin
        n_stage[0].bin = i_value;
        n_stage[0].bcd = '0;
        n_stage[0].neg = r_signed_mode & i_value[31];
        n_stage[1]     = r_stage[0];
        if (r_stage[0].neg) begin
            n_stage[1].bin = 32'd0 - r_stage[0].bin;
        end
        for (int k = 2; k < NST; k++) begin
            n_stage[k] = i2dtxt_pkg::dd_steps(r_stage[k-1]);
        end
    end

    // Stage load enables: a stage loads when empty or when it moves on
    always_comb begin
        ld[NST] = ser_can_load;
        for (int k = NST - 1; k >= 0; k--) begin
            ld[k] = !r_valid[k] || ld[k+1];
        end
    end

    assign o_in_ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (ld[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ld[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (ld[k]) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    // Character slots of the converted word: which are shown and what they hold
    always_comb begin
        any_nz = 1'b0;
        for (int p = 0; p < ND; p++) begin
            digit[p] = r_stage[NST-1].bcd[4*(ND-1-p) +: 4];
            any_nz   = any_nz | (digit[p] != 4'd0);
            nz_le[p] = any_nz;
            open_cnt[p] = (r_min_digits <= 4'd10)
                       && ({1'b0, r_min_digits} + 5'(p) >= 5'd10);
        end
        n_mask = '0;
        for (int s = 0; s < NSL; s++) begin
            n_chars[s] = r_group_separator;
        end
        n_mask[i2dtxt_pkg::SLOT_MINUS]  = r_stage[NST-1].neg;
        n_chars[i2dtxt_pkg::SLOT_MINUS] = i2dtxt_pkg::CH_MINUS;
        for (int p = 0; p < ND; p++) begin
            n_mask[i2dtxt_pkg::DIGIT_SLOT[p]] = nz_le[p] | open_cnt[p] | (p == ND - 1);
            if (nz_le[p]) begin
                n_chars[i2dtxt_pkg::DIGIT_SLOT[p]] = i2dtxt_pkg::CH_ZERO + {4'd0, digit[p]};
            end else if (p == ND - 1) begin
                n_chars[i2dtxt_pkg::DIGIT_SLOT[p]] = i2dtxt_pkg::CH_ZERO;
            end else begin
                n_chars[i2dtxt_pkg::DIGIT_SLOT[p]] = i2dtxt_pkg::CH_SPACE;
            end
        end
        for (int g = 0; g < i2dtxt_pkg::SEP_COUNT; g++) begin
            n_mask[i2dtxt_pkg::SEP_SLOT[g]] = (r_group_separator != 8'd0)
                && (nz_le[i2dtxt_pkg::SEP_POS[g] - 1] | open_cnt[i2dtxt_pkg::SEP_POS[g]]);
        end
    end

    // Serializer: lowest pending slot goes out first
    assign onehot = r_mask & (~r_mask + {{(NSL-1){1'b0}}, 1'b1});
    assign rest   = r_mask & ~onehot;
    assign emit   = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign ser_can_load = (r_mask == '0) || (emit && (rest == '0));
    assign ser_load     = r_valid[NST-1] && ser_can_load;

    always_comb begin
        sel_char = 8'd0;
        for (int s = 0; s < NSL; s++) begin
            sel_char = sel_char | (r_chars[s] & {8{onehot[s]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (ser_load) begin
            r_mask <= n_mask;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            for (int s = 0; s < NSL; s++) begin
                r_chars[s] <= n_chars[s];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char  <= sel_char;
            r_last_char <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last_char;

endmodule

// File: rtl/i2dtxt_checker.sv
// Port-level checks for the integer-to-decimal text core, bound to the top level.
module i2dtxt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_char,
    input logic        o_last_char
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // A stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("stalled output word changed");

    // No character is ever NUL: separator is only shown when set
    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_char != 8'h00)
        else $error("NUL character emitted");

    // Text always ends in the units digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_char |->
            (o_out_char >= i2dtxt_pkg::CH_ZERO) && (o_out_char <= i2dtxt_pkg::CH_NINE))
        else $error("final character is not a digit");

endmodule

bind integer_to_padded_decimal_text_core i2dtxt_checker u_i2dtxt_checker (.*);
